// ===== src/wgo_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the
// wheel/gyro odometry integrator. No dependencies.
package wgo_pkg;

  typedef struct packed {
    logic               right_reverse;
    logic               left_reverse;
    logic signed [15:0] right_count;
    logic signed [15:0] left_count;
    logic signed [15:0] yaw_rate;
    logic        [15:0] interval;
    logic               load_pose;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [19:0] pose_heading;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [19:0] heading_out;
    logic signed [31:0] step_x;
    logic signed [31:0] step_y;
  } out_item_t;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_IW      = $clog2(ATAN_ENTRIES);

  // CORDIC datapath word: Q30 angles and coordinates, with headroom
  localparam int CORDIC_W = 34;
  localparam logic [CORDIC_W-1:0] CORDIC_GAIN = 34'd652032874;

  // shared serial multiplier: signed multiplicand x signed multiplier
  localparam int MUL_AW = 36;
  localparam int MUL_BW = CORDIC_W;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  function automatic logic [CORDIC_W-1:0] atan_q30(input logic [ATAN_IW-1:0] idx);
    logic [CORDIC_W-1:0] v;
    case (idx)
      5'd0:    v = 34'd843314856;
      5'd1:    v = 34'd497837829;
      5'd2:    v = 34'd263043836;
      5'd3:    v = 34'd133525158;
      5'd4:    v = 34'd67021686;
      5'd5:    v = 34'd33543515;
      5'd6:    v = 34'd16775850;
      5'd7:    v = 34'd8388437;
      5'd8:    v = 34'd4194282;
      5'd9:    v = 34'd2097149;
      5'd10:   v = 34'd1048575;
      5'd11:   v = 34'd524287;
      5'd12:   v = 34'd262143;
      5'd13:   v = 34'd131071;
      5'd14:   v = 34'd65535;
      5'd15:   v = 34'd32767;
      5'd16:   v = 34'd16383;
      5'd17:   v = 34'd8191;
      5'd18:   v = 34'd4095;
      5'd19:   v = 34'd2047;
      5'd20:   v = 34'd1023;
      5'd21:   v = 34'd511;
      5'd22:   v = 34'd255;
      5'd23:   v = 34'd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/wgo_mul.sv =====
// Serial signed multiplier, one multiplier bit per cycle (shift-add with
// final subtract for the sign bit). Depends on wgo_pkg.
module wgo_mul import wgo_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MUL_AW-1:0] a_i,
  input  logic [MUL_BW-1:0] b_i,
  output logic              done_o,
  output logic [MUL_PW-1:0] prod_o
);

  localparam int CNTW = $clog2(MUL_BW);

  logic [MUL_AW-1:0] a_q;
  logic [MUL_AW:0]   hi_q, hi_d;
  logic [MUL_BW-1:0] lo_q, lo_d;
  logic [CNTW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic              last;
  logic [MUL_AW:0]   addend;
  logic [MUL_AW+1:0] sum;

  always_comb begin
    last   = (cnt_q == CNTW'(MUL_BW - 1));
    addend = lo_q[0] ? {a_q[MUL_AW-1], a_q} : '0;
    // the multiplier's top bit has negative weight
    if (last) begin
      sum = {hi_q[MUL_AW], hi_q} - {addend[MUL_AW], addend};
    end else begin
      sum = {hi_q[MUL_AW], hi_q} + {addend[MUL_AW], addend};
    end

    hi_d   = hi_q;
    lo_d   = lo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      hi_d   = '0;
      lo_d   = b_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      hi_d  = sum[MUL_AW+1:1];
      lo_d  = {sum[0], lo_q[MUL_BW-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
    end
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign done_o = done_q;
  assign prod_o = {hi_q[MUL_AW-1:0], lo_q};

endmodule

// ===== src/wgo_cordic.sv =====
// Digit-serial rotation-mode CORDIC: each iteration streams x, y and the
// residual angle through narrow adders, two bits per cycle. Depends on wgo_pkg.
module wgo_cordic import wgo_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [CORDIC_W-1:0] angle_i,
  output logic                done_o,
  output logic [CORDIC_W-1:0] x_o,
  output logic [CORDIC_W-1:0] y_o
);

  localparam int DIGIT = 2;
  localparam int NDIG  = CORDIC_W / DIGIT;
  localparam int DGW   = $clog2(NDIG);
  localparam int ITW   = $clog2(CORDIC_STEPS);
  localparam int EXW   = CORDIC_W + ATAN_ENTRIES;
  localparam int IDXW  = $clog2(EXW);

  logic [CORDIC_W-1:0] x_q, x_d, y_q, y_d, a_q, a_d;
  logic [CORDIC_W-1:0] xn_q, xn_d, yn_q, yn_d, an_q, an_d;
  logic                cx_q, cx_d, cy_q, cy_d, ca_q, ca_d;
  logic [DGW-1:0]      dig_q, dig_d;
  logic [ITW-1:0]      iter_q, iter_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;

  logic [EXW-1:0]      xx, yx;
  logic [CORDIC_W-1:0] atan_w;
  logic [IDXW-1:0]     pos, sidx;
  logic                rot_pos, first, last_dig;
  logic [DIGIT:0]      xs, ys, as_sum;

  function automatic logic [DIGIT:0] dig_add(input logic [DIGIT-1:0] p,
                                             input logic [DIGIT-1:0] q,
                                             input logic             sub,
                                             input logic             cin);
    logic [DIGIT-1:0] qq;
    qq = sub ? ~q : q;
    return {1'b0, p} + {1'b0, qq} + {{DIGIT{1'b0}}, cin};
  endfunction

  always_comb begin
    xx       = {{ATAN_ENTRIES{x_q[CORDIC_W-1]}}, x_q};
    yx       = {{ATAN_ENTRIES{y_q[CORDIC_W-1]}}, y_q};
    atan_w   = atan_q30(ATAN_IW'(iter_q));
    pos      = IDXW'(dig_q) * IDXW'(DIGIT);
    sidx     = pos + IDXW'(iter_q);
    rot_pos  = ~a_q[CORDIC_W-1];
    first    = (dig_q == '0);
    last_dig = (dig_q == DGW'(NDIG - 1));

    // rotate toward zero residual: x -= y>>i, y += x>>i, a -= atan when a >= 0
    xs     = dig_add(x_q[pos +: DIGIT], yx[sidx +: DIGIT], rot_pos,
                     first ? rot_pos : cx_q);
    ys     = dig_add(y_q[pos +: DIGIT], xx[sidx +: DIGIT], ~rot_pos,
                     first ? ~rot_pos : cy_q);
    as_sum = dig_add(a_q[pos +: DIGIT], atan_w[pos +: DIGIT], rot_pos,
                     first ? rot_pos : ca_q);

    x_d    = x_q;
    y_d    = y_q;
    a_d    = a_q;
    xn_d   = xn_q;
    yn_d   = yn_q;
    an_d   = an_q;
    cx_d   = cx_q;
    cy_d   = cy_q;
    ca_d   = ca_q;
    dig_d  = dig_q;
    iter_d = iter_q;
    busy_d = busy_q;
    done_d = 1'b0;

    if (start_i) begin
      x_d    = CORDIC_GAIN;
      y_d    = '0;
      a_d    = angle_i;
      dig_d  = '0;
      iter_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      xn_d = {xs[DIGIT-1:0], xn_q[CORDIC_W-1:DIGIT]};
      yn_d = {ys[DIGIT-1:0], yn_q[CORDIC_W-1:DIGIT]};
      an_d = {as_sum[DIGIT-1:0], an_q[CORDIC_W-1:DIGIT]};
      cx_d = xs[DIGIT];
      cy_d = ys[DIGIT];
      ca_d = as_sum[DIGIT];
      if (last_dig) begin
        x_d    = xn_d;
        y_d    = yn_d;
        a_d    = an_d;
        dig_d  = '0;
        iter_d = iter_q + 1'b1;
        if (iter_q == ITW'(CORDIC_STEPS - 1)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end else begin
        dig_d = dig_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig_q  <= '0;
      iter_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      dig_q  <= dig_d;
      iter_q <= iter_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    y_q  <= y_d;
    a_q  <= a_d;
    xn_q <= xn_d;
    yn_q <= yn_d;
    an_q <= an_d;
    cx_q <= cx_d;
    cy_q <= cy_d;
    ca_q <= ca_d;
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;

endmodule

// ===== src/wheel_gyro_odometry_integrator.sv =====
// Top level: request sequencer, pose state and result register of the
// wheel/gyro odometry integrator. Depends on wgo_pkg, wgo_mul, wgo_cordic.
//
//   channel | signals                            | payload
//   --------+------------------------------------+-------------------------
//   in      | in_valid_i / in_ready_o            | in_data_i  (in_item_t)
//   out     | out_valid_o / out_ready_i          | out_data_o (out_item_t)
//   cfg     | cfg_valid_i / cfg_ready_o          | cfg_data_i (encoder_scale)
//
// An integrating request makes six passes through the serial multiplier (one
// multiplier bit per cycle) and CORDIC_STEPS iterations in the two-bit-digit
// CORDIC, plus the angle and heading reduction states. A pose load uses
// neither unit: it goes through S_LOAD and S_DONE only.
// One request is in work at a time; a new one is taken while the previous
// result waits in the output register. Reset clears pose and sets the scale.
module wheel_gyro_odometry_integrator import wgo_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SPEED = 5'd1;
  localparam logic [4:0] S_ANG0  = 5'd2;
  localparam logic [4:0] S_ANG1  = 5'd3;
  localparam logic [4:0] S_ANG2  = 5'd4;
  localparam logic [4:0] S_CORD  = 5'd5;
  localparam logic [4:0] S_MULCX = 5'd6;
  localparam logic [4:0] S_STEPX = 5'd7;
  localparam logic [4:0] S_MULSY = 5'd8;
  localparam logic [4:0] S_STEPY = 5'd9;
  localparam logic [4:0] S_YAW   = 5'd10;
  localparam logic [4:0] S_HEAD1 = 5'd11;
  localparam logic [4:0] S_HEAD2 = 5'd12;
  localparam logic [4:0] S_POS   = 5'd13;
  localparam logic [4:0] S_LOAD  = 5'd14;
  localparam logic [4:0] S_DONE  = 5'd15;

  localparam logic signed [CORDIC_W-1:0] ANG_PI      = 34'sd3373259426;
  localparam logic signed [CORDIC_W-1:0] ANG_HALF_PI = 34'sd1686629713;
  localparam logic signed [CORDIC_W-1:0] ANG_TWO_PI  = 34'sd6746518852;
  localparam logic signed [21:0]         HEAD_WRAP   = 22'sd411775;
  localparam logic [15:0]                SCALE_RST   = 16'd655;

  logic [4:0]                  state_q, state_d;
  logic                        kick_q, kick_d;
  logic                        out_valid_q, out_valid_d;
  logic [15:0]                 scale_q, scale_d;
  logic signed [31:0]          pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic signed [19:0]          heading_q, heading_d;

  in_item_t                    in_q, in_d;
  out_item_t                   out_q, out_d;
  logic [31:0]                 speed_q, speed_d;
  logic signed [CORDIC_W-1:0]  ang_q, ang_d;
  logic                        flip_q, flip_d;
  logic [CORDIC_W-1:0]         cos_q, cos_d, sin_q, sin_d;
  logic [MUL_AW-1:0]           t_q, t_d;
  logic signed [31:0]          stepx_q, stepx_d, stepy_q, stepy_d;
  logic signed [21:0]          hs_q, hs_d;

  logic                        in_acc;
  logic signed [17:0]          rc18, lc18, mix;
  logic [MUL_AW-1:0]           mul_a;
  logic [MUL_BW-1:0]           mul_b, dt_b;
  logic                        mul_start, mul_done;
  logic [MUL_PW-1:0]           prod;
  logic                        cord_start, cord_done;
  logic [CORDIC_W-1:0]         cord_x, cord_y;
  logic [33:0]                 sum_rnd;
  logic signed [20:0]          dh;
  logic signed [35:0]          psx, psy;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // truncating remainder step: pull the heading one wrap period toward zero
  function automatic logic signed [21:0] wrap_step(input logic signed [21:0] h);
    logic signed [21:0] r;
    if (!h[21] && h >= HEAD_WRAP) begin
      r = h - HEAD_WRAP;
    end else if (h[21] && h <= -HEAD_WRAP) begin
      r = h + HEAD_WRAP;
    end else begin
      r = h;
    end
    return r;
  endfunction

  wgo_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  wgo_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .angle_i (ang_q),
    .done_o  (cord_done),
    .x_o     (cord_x),
    .y_o     (cord_y)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign mul_start   = kick_q & (state_q != S_CORD);
  assign cord_start  = kick_q & (state_q == S_CORD);

  always_comb begin
    // (+-right) + (+-left) scaled once: equals the sum of the scaled wheels
    rc18    = {{2{in_q.right_count[15]}}, in_q.right_count};
    lc18    = {{2{in_q.left_count[15]}}, in_q.left_count};
    mix     = (in_q.right_reverse ? -rc18 : rc18) + (in_q.left_reverse ? -lc18 : lc18);
    dt_b    = {{(MUL_BW-16){1'b0}}, in_q.interval};

    case (state_q)
      S_SPEED: begin
        mul_a = {{(MUL_AW-18){mix[17]}}, mix};
        mul_b = {{(MUL_BW-16){1'b0}}, scale_q};
      end
      S_MULCX: begin
        mul_a = {{(MUL_AW-32){speed_q[31]}}, speed_q};
        mul_b = cos_q;
      end
      S_MULSY: begin
        mul_a = {{(MUL_AW-32){speed_q[31]}}, speed_q};
        mul_b = sin_q;
      end
      S_YAW: begin
        mul_a = {{(MUL_AW-16){in_q.yaw_rate[15]}}, in_q.yaw_rate};
        mul_b = dt_b;
      end
      default: begin
        mul_a = t_q;
        mul_b = dt_b;
      end
    endcase

    sum_rnd = prod[33:0] + {33'd0, prod[33]};
    dh      = prod[32:12];
    psx     = {{4{pos_x_q[31]}}, pos_x_q} + {{4{stepx_q[31]}}, stepx_q};
    psy     = {{4{pos_y_q[31]}}, pos_y_q} + {{4{stepy_q[31]}}, stepy_q};

    state_d     = state_q;
    out_valid_d = out_valid_q;
    scale_d     = scale_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    heading_d   = heading_q;
    in_d        = in_q;
    out_d       = out_q;
    speed_d     = speed_q;
    ang_d       = ang_q;
    flip_d      = flip_q;
    cos_d       = cos_q;
    sin_d       = sin_q;
    t_d         = t_q;
    stepx_d     = stepx_q;
    stepy_d     = stepy_q;
    hs_d        = hs_q;

    if (cfg_valid_i) begin
      scale_d = cfg_data_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          in_d    = in_data_i;
          state_d = in_data_i.load_pose ? S_LOAD : S_SPEED;
        end
      end
      S_SPEED: begin
        if (mul_done) begin
          // halve, truncating toward zero
          speed_d = sum_rnd[32:1];
          state_d = S_ANG0;
        end
      end
      S_ANG0: begin
        ang_d   = {heading_q, 14'd0};
        state_d = S_ANG1;
      end
      S_ANG1: begin
        if (ang_q > ANG_PI) begin
          ang_d = ang_q - ANG_TWO_PI;
        end else if (ang_q < -ANG_PI) begin
          ang_d = ang_q + ANG_TWO_PI;
        end
        state_d = S_ANG2;
      end
      S_ANG2: begin
        // fold into the CORDIC range; the half turn negates cos and sin
        flip_d = 1'b1;
        if (ang_q > ANG_HALF_PI) begin
          ang_d = ang_q - ANG_PI;
        end else if (ang_q < -ANG_HALF_PI) begin
          ang_d = ang_q + ANG_PI;
        end else begin
          flip_d = 1'b0;
        end
        state_d = S_CORD;
      end
      S_CORD: begin
        if (cord_done) begin
          cos_d   = flip_q ? CORDIC_W'(0) - cord_x : cord_x;
          sin_d   = flip_q ? CORDIC_W'(0) - cord_y : cord_y;
          state_d = S_MULCX;
        end
      end
      S_MULCX: begin
        if (mul_done) begin
          t_d     = prod[65:30];
          state_d = S_STEPX;
        end
      end
      S_STEPX: begin
        if (mul_done) begin
          stepx_d = sat32(prod[51:16]);
          state_d = S_MULSY;
        end
      end
      S_MULSY: begin
        if (mul_done) begin
          t_d     = prod[65:30];
          state_d = S_STEPY;
        end
      end
      S_STEPY: begin
        if (mul_done) begin
          stepy_d = sat32(prod[51:16]);
          state_d = S_YAW;
        end
      end
      S_YAW: begin
        if (mul_done) begin
          hs_d    = {{2{heading_q[19]}}, heading_q} + {dh[20], dh};
          state_d = S_HEAD1;
        end
      end
      S_HEAD1: begin
        hs_d    = wrap_step(hs_q);
        state_d = S_HEAD2;
      end
      S_HEAD2: begin
        hs_d    = wrap_step(hs_q);
        state_d = S_POS;
      end
      S_POS: begin
        pos_x_d   = sat32(psx);
        pos_y_d   = sat32(psy);
        heading_d = hs_q[19:0];
        state_d   = S_DONE;
      end
      S_LOAD: begin
        pos_x_d   = in_q.pose_x;
        pos_y_d   = in_q.pose_y;
        heading_d = in_q.pose_heading;
        stepx_d   = '0;
        stepy_d   = '0;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.position_x  = pos_x_q;
          out_d.position_y  = pos_y_q;
          out_d.heading_out = heading_q;
          out_d.step_x      = stepx_q;
          out_d.step_y      = stepy_q;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // one-cycle start pulse on entry to a state that runs a unit
    kick_d = (state_d != state_q) &&
             (state_d inside {S_SPEED, S_CORD, S_MULCX, S_STEPX, S_MULSY, S_STEPY, S_YAW});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kick_q      <= 1'b0;
      out_valid_q <= 1'b0;
      scale_q     <= SCALE_RST;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      heading_q   <= '0;
    end else begin
      state_q     <= state_d;
      kick_q      <= kick_d;
      out_valid_q <= out_valid_d;
      scale_q     <= scale_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      heading_q   <= heading_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q    <= in_d;
    out_q   <= out_d;
    speed_q <= speed_d;
    ang_q   <= ang_d;
    flip_q  <= flip_d;
    cos_q   <= cos_d;
    sin_q   <= sin_d;
    t_q     <= t_d;
    stepx_q <= stepx_d;
    stepy_q <= stepy_d;
    hs_q    <= hs_d;
  end

endmodule
